@@ sv/bce_pkg.sv @@
// Shared types, widths and helper functions of the Bezier curve evaluator.
`default_nettype none

package bce_pkg;

  // Curve order (1..7) and register file size
  localparam int ORDER     = 7;
  localparam int NCOEFF    = 8;
  localparam int CIDX_W    = 3;
  localparam int CFG_IDX_W = 4;

  // Field widths
  localparam int COEF_W = 16;
  localparam int T_W    = 16;
  localparam int FRAC_W = 15;
  localparam int POS_W  = 16;
  localparam int SLP_W  = 20;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  localparam logic [T_W-1:0] ONE_T = T_W'(32768);

  // Horner accumulators are kept modulo 2^ACC_W; only the low bits up to
  // the rounded result field matter.
  localparam int ACC_W  = FRAC_W * ORDER + POS_W;
  localparam int LIMB_W = 32;
  localparam int NLIMB  = (ACC_W + LIMB_W - 1) / LIMB_W;
  localparam int PP_W   = LIMB_W + T_W;
  localparam int PAD_W  = NLIMB * LIMB_W + T_W;

  // Power-basis coefficients and their update weights
  localparam int PA_W = 17 + 2 * ORDER;
  localparam int WT_W = 2 * ORDER + 2;

  // Final rounding shifts
  localparam int POS_SH = FRAC_W * ORDER;
  localparam int SLP_SH = FRAC_W * (ORDER - 1);

  typedef logic [ACC_W-1:0]          acc_t;
  typedef logic signed [ACC_W-1:0]   acc_s_t;
  typedef logic [PP_W-1:0]           pp_t;
  typedef logic [PAD_W-1:0]          pad_t;
  typedef logic [PA_W-1:0]           pa_t;
  typedef logic signed [PA_W-1:0]    pa_s_t;
  typedef logic [NLIMB-1:0][LIMB_W-1:0] limbs_t;
  typedef logic [NLIMB-1:0][PP_W-1:0]   pp_vec_t;
  typedef logic [NCOEFF-1:0][COEF_W-1:0] coeff_vec_t;
  typedef logic [ORDER:0][PA_W-1:0]      pa_vec_t;
  typedef logic [ORDER:0][WT_W-1:0]      wt_vec_t;

  localparam acc_t POS_HALF = acc_t'(1) << (POS_SH - 1);
  localparam acc_t SLP_HALF = (acc_t'(1) << SLP_SH) >> 1;

  // One beat moving down the cell chain
  typedef struct packed {
    logic           valid;
    logic [T_W-1:0] t;
    acc_t           p;
    acc_t           d;
  } beat_t;

  // Binomial coefficient by Pascal rows (constant arguments only)
  function automatic int binom(input int n, input int k);
    int row [NCOEFF];
    for (int i = 0; i < NCOEFF; i++) row[i] = (i == 0) ? 1 : 0;
    for (int r = 1; r <= n; r++) begin
      for (int i = NCOEFF - 1; i >= 1; i--) row[i] = row[i] + row[i-1];
    end
    if (k < 0 || k >= NCOEFF) return 0;
    return row[k];
  endfunction

  // Weight of control coefficient j in power-basis coefficient k
  function automatic int pa_weight(input int k, input int j);
    int w;
    if (j > k) return 0;
    w = binom(ORDER, k) * binom(k, j);
    if (((k - j) & 1) != 0) return -w;
    return w;
  endfunction

  // Sum of limb partial products; even limbs do not overlap each other, nor do odd ones
  function automatic acc_t pp_fold(input pp_vec_t pp);
    pad_t ev;
    pad_t od;
    ev = '0;
    od = '0;
    for (int l = 0; l < NLIMB; l++) begin
      if (l[0] == 1'b0) ev = ev | (pad_t'(pp[l]) << (LIMB_W * l));
      else od = od | (pad_t'(pp[l]) << (LIMB_W * l));
    end
    return acc_t'(ev + od);
  endfunction

endpackage

`default_nettype wire

@@ sv/bezier_curve_eval_unit.sv @@
// Top level of the Bezier curve evaluator: stream ports, cell chain, rounding.
`default_nettype none

// Evaluates a one-dimensional Bezier curve of order bce_pkg::ORDER at each
// incoming t (unsigned Q1.15, values above 1.0 are clamped to 1.0) and returns
// the curve position (signed Q7.8) and its first derivative with respect to t
// (signed Q11.8), both rounded to nearest with ties toward plus infinity.
// The control coefficients are held in a power-basis form that is updated on
// every coefficient write, so the datapath is a Horner recurrence carried out
// by a row of ORDER identical cells; each cell does one step for the value and
// one for the derivative, both exact modulo 2^ACC_W. Throughput is one beat
// per clock while out_tready is held high. The pipeline holds one input
// register, two stages per cell (32x16 limb multiplies, then the limb fold
// and add) and the output register with the final rounding. Empty stages
// collapse, so the chain keeps accepting beats into empty stages while a result
// waits on out_tready. Coefficient writes are taken every cycle and must only
// be made while no beat is in flight; there is no clearing pass after reset.
module bezier_curve_eval_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bce_pkg::IN_DATA_W-1:0]    in_tdata,   // [15:0] param_t
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bce_pkg::OUT_DATA_W-1:0]   out_tdata,  // [15:0] position,
                                                       // [35:16] slope, pad
  // coefficient writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bce_pkg::COEF_W-1:0]       cfg_data
);

  bce_pkg::pa_vec_t           pa;
  bce_pkg::beat_t             beat [bce_pkg::ORDER+1];
  bce_pkg::acc_t              addend [bce_pkg::ORDER+1];
  logic [bce_pkg::ORDER:0]    ld;

  logic                       v0_r;
  logic [bce_pkg::T_W-1:0]    t0_r;
  logic [bce_pkg::T_W-1:0]    t0_nxt;
  logic                       ld0;

  logic                       out_valid_r;
  logic [bce_pkg::POS_W-1:0]  pos_r;
  logic [bce_pkg::SLP_W-1:0]  slp_r;
  bce_pkg::acc_t              pos_sum;
  bce_pkg::acc_t              slp_sum;

  // Coefficient registers in power-basis form
  bce_basis u_basis (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pa        (pa)
  );

  // Input register, t clamped to 1.0
  assign ld0       = !v0_r || ld[0];
  assign in_tready = ld0;
  assign t0_nxt    = (in_tdata[bce_pkg::T_W-1:0] > bce_pkg::ONE_T) ? bce_pkg::ONE_T
                                                                   : in_tdata[bce_pkg::T_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (ld0) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld0 && in_tvalid) t0_r <= t0_nxt;
  end

  // Horner start: value = leading power coefficient, derivative = 0.
  // The coefficient is read while the beat sits in the input register.
  always_comb begin
    beat[0].valid = v0_r;
    beat[0].t     = t0_r;
    beat[0].p     = bce_pkg::acc_t'(bce_pkg::acc_s_t'(signed'(pa[bce_pkg::ORDER])));
    beat[0].d     = '0;
  end

  // Cell j adds power coefficient ORDER-j scaled by 2^(15*j)
  for (genvar j = 1; j <= bce_pkg::ORDER; j++) begin : g_cell
    assign addend[j] = bce_pkg::acc_t'(bce_pkg::acc_s_t'(signed'(pa[bce_pkg::ORDER-j])))
                       << (bce_pkg::FRAC_W * j);

    bce_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .up     (beat[j-1]),
      .addend (addend[j]),
      .dn_ld  (ld[j]),
      .up_ld  (ld[j-1]),
      .dn     (beat[j])
    );
  end
  assign addend[0] = '0;

  // Output register with rounding of both sums
  assign ld[bce_pkg::ORDER] = !out_valid_r || out_tready;
  assign pos_sum = beat[bce_pkg::ORDER].p + bce_pkg::POS_HALF;
  assign slp_sum = beat[bce_pkg::ORDER].d + bce_pkg::SLP_HALF + addend[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld[bce_pkg::ORDER]) begin
      out_valid_r <= beat[bce_pkg::ORDER].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[bce_pkg::ORDER] && beat[bce_pkg::ORDER].valid) begin
      pos_r <= pos_sum[bce_pkg::POS_SH +: bce_pkg::POS_W];
      slp_r <= slp_sum[bce_pkg::SLP_SH +: bce_pkg::SLP_W];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(bce_pkg::OUT_DATA_W - bce_pkg::POS_W - bce_pkg::SLP_W)'(0),
                       slp_r, pos_r};

  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("chain stalls with an empty output register");

  a_t_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    beat[0].valid |-> beat[0].t <= bce_pkg::ONE_T)
    else $error("t above 1.0 entered the cell chain");

endmodule

`default_nettype wire

@@ sv/bce_basis.sv @@
// Coefficient registers and their power-basis form, updated on each write.
`default_nettype none

module bce_basis (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bce_pkg::COEF_W-1:0]     cfg_data,
  output bce_pkg::pa_vec_t               pa
);

  bce_pkg::coeff_vec_t          coeff_r;
  bce_pkg::pa_vec_t             pa_r;
  bce_pkg::pa_vec_t             pa_nxt;
  bce_pkg::wt_vec_t             wt;
  logic [bce_pkg::COEF_W-1:0]   old_c;
  logic signed [bce_pkg::COEF_W:0] delta;
  logic                         wr;

  assign cfg_ready = 1'b1;
  assign wr = cfg_valid && (cfg_index < bce_pkg::CFG_IDX_W'(bce_pkg::NCOEFF));
  assign old_c = coeff_r[cfg_index[bce_pkg::CIDX_W-1:0]];
  assign delta = signed'({cfg_data[bce_pkg::COEF_W-1], cfg_data})
               - signed'({old_c[bce_pkg::COEF_W-1], old_c});

  // each power coefficient moves by weight * (new - old)
  always_comb begin
    for (int k = 0; k <= bce_pkg::ORDER; k++) begin
      wt[k] = '0;
      for (int j = 0; j < bce_pkg::NCOEFF; j++) begin
        if (cfg_index == bce_pkg::CFG_IDX_W'(j))
          wt[k] = bce_pkg::WT_W'(bce_pkg::pa_weight(k, j));
      end
      pa_nxt[k] = bce_pkg::pa_t'(bce_pkg::pa_s_t'(signed'(pa_r[k]))
                + bce_pkg::pa_s_t'(signed'(wt[k])) * bce_pkg::pa_s_t'(delta));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= '0;
      pa_r    <= '0;
    end else if (wr) begin
      coeff_r[cfg_index[bce_pkg::CIDX_W-1:0]] <= cfg_data;
      pa_r <= pa_nxt;
    end
  end

  assign pa = pa_r;

endmodule

`default_nettype wire

@@ sv/bce_cell.sv @@
// One Horner cell: P <= P*T + addend and D <= D*T + P, two register stages.
`default_nettype none

module bce_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  bce_pkg::beat_t up,
  input  bce_pkg::acc_t  addend,
  input  logic           dn_ld,
  output logic           up_ld,
  output bce_pkg::beat_t dn
);

  logic                      va_r;
  logic                      vb_r;
  logic                      ld_b;
  logic [bce_pkg::T_W-1:0]   t_a_r;
  logic [bce_pkg::T_W-1:0]   t_b_r;
  bce_pkg::acc_t             p_a_r;
  bce_pkg::acc_t             p_b_r;
  bce_pkg::acc_t             d_b_r;
  bce_pkg::acc_t             p_b_nxt;
  bce_pkg::acc_t             d_b_nxt;
  bce_pkg::pp_vec_t          pp_p_a_r;
  bce_pkg::pp_vec_t          pp_d_a_r;
  bce_pkg::pp_vec_t          pp_p_a_nxt;
  bce_pkg::pp_vec_t          pp_d_a_nxt;
  bce_pkg::limbs_t           p_ext;
  bce_pkg::limbs_t           d_ext;

  // a stage loads when empty or when its successor loads
  assign ld_b  = !vb_r || dn_ld;
  assign up_ld = !va_r || ld_b;

  // stage A: 32x16 limb products, modulo 2^ACC_W overall
  always_comb begin
    p_ext = bce_pkg::limbs_t'(up.p);
    d_ext = bce_pkg::limbs_t'(up.d);
    for (int l = 0; l < bce_pkg::NLIMB; l++) begin
      pp_p_a_nxt[l] = bce_pkg::pp_t'(p_ext[l]) * bce_pkg::pp_t'(up.t);
      pp_d_a_nxt[l] = bce_pkg::pp_t'(d_ext[l]) * bce_pkg::pp_t'(up.t);
    end
  end

  // stage B: fold limbs and add
  assign p_b_nxt = bce_pkg::pp_fold(pp_p_a_r) + addend;
  assign d_b_nxt = bce_pkg::pp_fold(pp_d_a_r) + p_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (up_ld) va_r <= up.valid;
      if (ld_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ld && up.valid) begin
      t_a_r    <= up.t;
      p_a_r    <= up.p;
      pp_p_a_r <= pp_p_a_nxt;
      pp_d_a_r <= pp_d_a_nxt;
    end
    if (ld_b && va_r) begin
      t_b_r <= t_a_r;
      p_b_r <= p_b_nxt;
      d_b_r <= d_b_nxt;
    end
  end

  always_comb begin
    dn.valid = vb_r;
    dn.t     = t_b_r;
    dn.p     = p_b_r;
    dn.d     = d_b_r;
  end

  a_hold_a: assert property (@(posedge clk) disable iff (!rst_n)
    va_r && !ld_b |=> va_r && $stable(p_a_r) && $stable(t_a_r))
    else $error("stage A lost a stalled beat");

  a_hold_b: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r && !dn_ld |=> vb_r && $stable(p_b_r) && $stable(d_b_r))
    else $error("stage B lost a stalled beat");

  a_empty_ld: assert property (@(posedge clk) disable iff (!rst_n)
    !va_r |-> up_ld)
    else $error("empty cell refuses a beat");

endmodule

`default_nettype wire
